// File: design/peak_hold_slot_history_defines.svh
// Assertion macros for the peak-hold slot history RTL.
`ifndef PEAK_HOLD_SLOT_HISTORY_DEFINES_SVH
`define PEAK_HOLD_SLOT_HISTORY_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define PHS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("phs: same-cycle check failed");

// Check that a condition implies another in the following cycle.
`define PHS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("phs: next-cycle check failed");

`endif

// File: design/phs_pkg.sv
// Types and constants for the peak-hold slot history block.
`default_nettype none

package phs_pkg;

    localparam int SLOTS_DEFAULT = 256;
    localparam int QUEUE_DEPTH   = 4;

    localparam logic [15:0] UNITY        = 16'd4096;
    localparam logic [15:0] BOOST_THRESH = 16'd4100;
    localparam logic [15:0] CUT_THRESH   = 16'd4092;
    localparam logic [15:0] SPP_RESET    = 16'd1;
    localparam int          Q_FRAC       = 12;

    typedef enum logic [1:0] {
        GM_NONE  = 2'd0,
        GM_BOOST = 2'd1,
        GM_CUT   = 2'd2
    } gain_mode_t;

    typedef struct packed {
        logic [15:0] dry_peak;
        logic [15:0] filtered_peak;
        logic [15:0] wet_peak;
        logic [15:0] gain_scale;
        logic [15:0] envelope_level;
        logic [15:0] attack_level;
        logic [15:0] release_level;
    } frame_t;

    typedef struct packed {
        logic [7:0]  slot_index;
        logic [15:0] dry_value;
        logic [15:0] filtered_value;
        logic [15:0] output_value;
        logic [15:0] envelope_value;
        logic [15:0] attack_value;
        logic [15:0] release_value;
        logic        last_write;
    } result_t;

    // One pending slot write handed from the front to the back
    typedef struct packed {
        logic [7:0]  slot_index;
        logic [15:0] dry;
        logic [15:0] filtered;
        logic [15:0] wet;
        logic [15:0] envelope;
        logic [15:0] attack;
        logic [15:0] release_lvl;
        logic [15:0] gain;
        gain_mode_t  mode;
        logic        last;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    typedef struct packed {
        logic seed_pending;
        logic advance;
    } front_stat_t;

    function automatic logic [15:0] umax16(input logic [15:0] a, input logic [15:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic [15:0] umin16(input logic [15:0] a, input logic [15:0] b);
        return (a < b) ? a : b;
    endfunction

endpackage

`default_nettype wire

// File: design/peak_hold_slot_history.sv
// Top level of the peak-hold slot history block.
`default_nettype none

// Peak-hold decimator for a level-history display. Frames carry six unsigned Q4.12
// levels and a Q4.12 gain; the block holds the running level maxima for the current
// history slot, plus the largest gain boost (never below unity) and the smallest
// gain cut (never above unity), and emits one result word per frame with the six
// display values of the slot. The output level is the wet maximum, raised to the
// saturated dry maximum times the boost when the boost exceeds 1.001, or lowered
// to the dry maximum times the cut when the cut is below 0.999. After
// samples_per_slot frames (zero acts as one) the slot index advances modulo SLOTS,
// the accumulators restart from that frame and a second word seeds the new slot
// with the raw wet level; only the final word of a frame has last_write set.
// Flow: a frame that stays within its slot is taken whenever full is low; a frame
// that closes a slot holds full high until the seed word has been queued. The
// back end drains one word a cycle while pop keeps the output register free,
// through a multiply stage and an output register, so a result passes through
// the queue, the multiply stage and the output register once its frame is taken.
// A four-entry job queue decouples the accumulator front end from the back end,
// and the output register lets a new frame in while a finished word waits to be
// popped. Write samples_per_slot only while the block is idle; lowering it below
// the frames already counted closes the slot on the next frame.

`include "peak_hold_slot_history_defines.svh"

module peak_hold_slot_history
    import phs_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        push,
    output      logic        full,
    input  wire frame_t      frame,
    output      logic        empty,
    input  wire logic        pop,
    output      result_t     result
);

    queue_stat_t q_stat;
    front_stat_t front_stat;
    logic        q_push;
    logic        q_pop;
    job_t        q_wr_data;
    job_t        q_rd_data;

    // accumulate and classify each frame
    phs_front #(
        .SLOTS (SLOTS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .push        (push),
        .full        (full),
        .frame       (frame),
        .q_stat      (q_stat),
        .q_push      (q_push),
        .q_wr_data   (q_wr_data),
        .stat        (front_stat)
    );

    // hold slot writes until the back end is free
    phs_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_data),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .stat    (q_stat)
    );

    // scale, compare and present the result word
    phs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .q_rd_data (q_rd_data),
        .q_pop     (q_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

    // a pending seed word must block new frames
    `PHS_ASSERT_SAME(a_seed_blocks_input, front_stat.seed_pending, full)
    // a frame that closes its slot must leave a seed word pending
    `PHS_ASSERT_NEXT(a_seed_follows_advance, push && !full && front_stat.advance, front_stat.seed_pending)
    // the front end never writes into a full queue
    `PHS_ASSERT_SAME(a_queue_no_overflow, q_push, !q_stat.full)
    // the back end never reads an empty queue
    `PHS_ASSERT_SAME(a_queue_no_underflow, q_pop, !q_stat.empty)

endmodule

`default_nettype wire

// File: design/phs_front.sv
// Front end: takes frames, folds them into the slot accumulators, queues slot writes.
`default_nettype none

module phs_front
    import phs_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        push,
    output      logic        full,
    input  wire frame_t      frame,
    input  wire queue_stat_t q_stat,
    output      logic        q_push,
    output      job_t        q_wr_data,
    output      front_stat_t stat
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int EXT_W  = (SLOT_W > 8) ? SLOT_W : 8;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);

    logic [15:0]       spp_reg;
    logic [SLOT_W-1:0] pos_reg,  pos_next;
    logic [15:0]       fc_reg,   fc_next;
    logic [15:0]       dry_reg,  dry_next;
    logic [15:0]       filt_reg, filt_next;
    logic [15:0]       wet_reg,  wet_next;
    logic [15:0]       boost_reg, boost_next;
    logic [15:0]       cut_reg,  cut_next;
    logic [15:0]       env_reg,  env_next;
    logic [15:0]       att_reg,  att_next;
    logic [15:0]       rel_reg,  rel_next;
    logic              seed_pending_reg, seed_pending_next;
    job_t              seed_job_reg, seed_job_next;

    logic              accept;
    logic [16:0]       fc_inc;
    logic              advance;
    logic [SLOT_W-1:0] pos_wrap;
    logic [EXT_W-1:0]  pos_ext, wrap_ext;
    logic [15:0]       dry_acc, filt_acc, wet_acc, boost_acc, cut_acc;
    logic [15:0]       env_acc, att_acc, rel_acc;
    logic [15:0]       boost_raw, cut_raw;
    job_t              job_acc;

    assign full   = q_stat.full || seed_pending_reg;
    assign accept = push && !full;

    assign fc_inc   = {1'b0, fc_reg} + 17'd1;
    assign advance  = fc_inc >= {1'b0, spp_reg};
    assign pos_wrap = (pos_reg == SLOT_LAST) ? '0 : pos_reg + SLOT_W'(1);
    assign pos_ext  = EXT_W'(pos_reg);
    assign wrap_ext = EXT_W'(pos_wrap);

    assign boost_raw = umax16(UNITY, frame.gain_scale);
    assign cut_raw   = umin16(UNITY, frame.gain_scale);

    assign dry_acc   = umax16(dry_reg,   frame.dry_peak);
    assign filt_acc  = umax16(filt_reg,  frame.filtered_peak);
    assign wet_acc   = umax16(wet_reg,   frame.wet_peak);
    assign boost_acc = umax16(boost_reg, boost_raw);
    assign cut_acc   = umin16(cut_reg,   cut_raw);
    assign env_acc   = umax16(env_reg,   frame.envelope_level);
    assign att_acc   = umax16(att_reg,   frame.attack_level);
    assign rel_acc   = umax16(rel_reg,   frame.release_level);

    always_comb
    begin
        job_acc             = '0;
        job_acc.slot_index  = pos_ext[7:0];
        job_acc.dry         = dry_acc;
        job_acc.filtered    = filt_acc;
        job_acc.wet         = wet_acc;
        job_acc.envelope    = env_acc;
        job_acc.attack      = att_acc;
        job_acc.release_lvl = rel_acc;
        job_acc.last        = !advance;
        if (boost_acc > BOOST_THRESH)
        begin
            job_acc.mode = GM_BOOST;
            job_acc.gain = boost_acc;
        end
        else if (cut_acc < CUT_THRESH)
        begin
            job_acc.mode = GM_CUT;
            job_acc.gain = cut_acc;
        end
        else
        begin
            job_acc.mode = GM_NONE;
            job_acc.gain = '0;
        end
    end

    always_comb
    begin
        pos_next          = pos_reg;
        fc_next           = fc_reg;
        dry_next          = dry_reg;
        filt_next         = filt_reg;
        wet_next          = wet_reg;
        boost_next        = boost_reg;
        cut_next          = cut_reg;
        env_next          = env_reg;
        att_next          = att_reg;
        rel_next          = rel_reg;
        seed_pending_next = seed_pending_reg;
        seed_job_next     = seed_job_reg;

        // drop the seed once the queue has taken it
        if (seed_pending_reg && !q_stat.full)
        begin
            seed_pending_next = 1'b0;
        end

        if (accept)
        begin
            if (advance)
            begin
                pos_next   = pos_wrap;
                fc_next    = '0;
                dry_next   = frame.dry_peak;
                filt_next  = frame.filtered_peak;
                wet_next   = frame.wet_peak;
                boost_next = boost_raw;
                cut_next   = cut_raw;
                env_next   = frame.envelope_level;
                att_next   = frame.attack_level;
                rel_next   = frame.release_level;

                seed_pending_next         = 1'b1;
                seed_job_next.slot_index  = wrap_ext[7:0];
                seed_job_next.dry         = frame.dry_peak;
                seed_job_next.filtered    = frame.filtered_peak;
                seed_job_next.wet         = frame.wet_peak;
                seed_job_next.envelope    = frame.envelope_level;
                seed_job_next.attack      = frame.attack_level;
                seed_job_next.release_lvl = frame.release_level;
                seed_job_next.gain        = '0;
                seed_job_next.mode        = GM_NONE;
                seed_job_next.last        = 1'b1;
            end
            else
            begin
                fc_next    = fc_inc[15:0];
                dry_next   = dry_acc;
                filt_next  = filt_acc;
                wet_next   = wet_acc;
                boost_next = boost_acc;
                cut_next   = cut_acc;
                env_next   = env_acc;
                att_next   = att_acc;
                rel_next   = rel_acc;
            end
        end
    end

    assign q_push    = accept || (seed_pending_reg && !q_stat.full);
    assign q_wr_data = seed_pending_reg ? seed_job_reg : job_acc;

    assign stat.seed_pending = seed_pending_reg;
    assign stat.advance      = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spp_reg          <= SPP_RESET;
            pos_reg          <= '0;
            fc_reg           <= '0;
            dry_reg          <= '0;
            filt_reg         <= '0;
            wet_reg          <= '0;
            boost_reg        <= UNITY;
            cut_reg          <= UNITY;
            env_reg          <= '0;
            att_reg          <= '0;
            rel_reg          <= '0;
            seed_pending_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                spp_reg <= cfg_wr_data;
            end
            pos_reg          <= pos_next;
            fc_reg           <= fc_next;
            dry_reg          <= dry_next;
            filt_reg         <= filt_next;
            wet_reg          <= wet_next;
            boost_reg        <= boost_next;
            cut_reg          <= cut_next;
            env_reg          <= env_next;
            att_reg          <= att_next;
            rel_reg          <= rel_next;
            seed_pending_reg <= seed_pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seed_job_reg <= seed_job_next;
    end

endmodule

`default_nettype wire

// File: design/phs_queue.sv
// Short job queue between the front end and the back end.
`default_nettype none

module phs_queue
    import phs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        wr_en,
    input  wire job_t        wr_data,
    input  wire logic        rd_en,
    output      job_t        rd_data,
    output      queue_stat_t stat
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    job_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             do_wr, do_rd;

    assign stat.full  = (count_reg == CNT_FULL);
    assign stat.empty = (count_reg == '0);
    assign do_wr      = wr_en && !stat.full;
    assign do_rd      = rd_en && !stat.empty;
    assign rd_data    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// File: design/phs_back.sv
// Back end: scales the dry maximum, forms the display output level, holds the result word.
`default_nettype none

module phs_back
    import phs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire queue_stat_t q_stat,
    input  wire job_t        q_rd_data,
    output      logic        q_pop,
    output      logic        empty,
    input  wire logic        pop,
    output      result_t     result
);

    logic        s1_valid_reg, s1_valid_next;
    job_t        s1_job_reg;
    logic [31:0] s1_prod_reg;
    logic        out_valid_reg, out_valid_next;
    result_t     out_reg;

    logic        out_ready, s1_ready;
    logic [19:0] prod_shr;
    logic [15:0] scaled;
    logic [15:0] level;

    assign out_ready = !out_valid_reg || pop;
    assign s1_ready  = !s1_valid_reg || out_ready;
    assign q_pop     = s1_ready && !q_stat.empty;

    // saturate the Q4.12 product to 16 bits
    assign prod_shr = s1_prod_reg[31:Q_FRAC];
    assign scaled   = (|prod_shr[19:16]) ? 16'hFFFF : prod_shr[15:0];

    always_comb
    begin
        case (s1_job_reg.mode)
            GM_BOOST: level = umax16(s1_job_reg.wet, scaled);
            GM_CUT:   level = umin16(s1_job_reg.wet, scaled);
            default:  level = s1_job_reg.wet;
        endcase
    end

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = s1_valid_reg;
        end
        if (s1_ready)
        begin
            s1_valid_next = q_pop;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_job_reg  <= q_rd_data;
            s1_prod_reg <= {16'd0, q_rd_data.dry} * {16'd0, q_rd_data.gain};
        end
        if (out_ready && s1_valid_reg)
        begin
            out_reg.slot_index     <= s1_job_reg.slot_index;
            out_reg.dry_value      <= s1_job_reg.dry;
            out_reg.filtered_value <= s1_job_reg.filtered;
            out_reg.output_value   <= level;
            out_reg.envelope_value <= s1_job_reg.envelope;
            out_reg.attack_value   <= s1_job_reg.attack;
            out_reg.release_value  <= s1_job_reg.release_lvl;
            out_reg.last_write     <= s1_job_reg.last;
        end
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

endmodule

`default_nettype wire
